>>> rtl/core/ple_pkg.sv
package ple_pkg;

    // Request codes
    localparam logic [2:0] REQ_INSERT  = 3'd0;
    localparam logic [2:0] REQ_REMOVE  = 3'd1;
    localparam logic [2:0] REQ_READ    = 3'd2;
    localparam logic [2:0] REQ_REPLACE = 3'd3;
    localparam logic [2:0] REQ_CLEAR   = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // One finished result, sequencer to output stage
    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [6:0]         list_count;
        logic               is_empty;
    } result_t;

endpackage

>>> rtl/core/ple_mem.sv
module ple_mem
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/ple_seq.sv
module ple_seq
    import ple_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int LW       = 7
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic [6:0]         position,
    input  logic signed [31:0] value,
    output logic               res_valid,
    input  logic               res_take,
    output result_t            res,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [31:0]        mem_wdata,
    output logic [AW-1:0]      mem_raddr,
    input  logic [31:0]        mem_rdata
);

    localparam int CW = (LW > 7) ? LW : 7;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [1:0] M_INS = 2'd0;
    localparam logic [1:0] M_REM = 2'd1;
    localparam logic [1:0] M_RD  = 2'd2;
    localparam logic [1:0] M_REP = 2'd3;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    mode_reg, mode_next;
    logic [AW-1:0] pos_m1_reg, pos_m1_next;
    logic [31:0]   val_reg, val_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] lim_reg, lim_next;
    logic [LW-1:0] len_reg, len_next;
    logic [1:0]    st_reg, st_next;
    logic [31:0]   rd_reg, rd_next;

    logic [CW-1:0] pos_ext, len_ext, pos_m1_ext;
    logic          pos_ok, ins_ok, is_full, is_append, is_last;
    logic [AW-1:0] idx_step;
    logic          step_end;

    // Position checks against the current length
    always_comb
    begin
        pos_ext    = CW'(position);
        len_ext    = CW'(len_reg);
        pos_m1_ext = pos_ext - CW'(1);
        pos_ok     = (position != 7'd0) && (pos_ext <= len_ext);
        ins_ok     = (position != 7'd0) && (pos_ext <= len_ext + CW'(1));
        is_full    = (len_ext == CW'(CAPACITY));
        is_append  = (pos_m1_ext == len_ext);
        is_last    = (pos_ext == len_ext);
    end

    // Shared index unit: step one entry (down for insert, up for remove), compare with the limit
    always_comb
    begin
        idx_step = (mode_reg == M_INS) ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));
        step_end = (idx_step == lim_reg);
    end

    // Entry RAM access
    always_comb
    begin
        mem_raddr = (mode_reg == M_RD) ? pos_m1_reg : idx_step;
        mem_we    = ((state_reg == S_WR) && (mode_reg != M_RD)) || (state_reg == S_FIN);
        mem_waddr = (state_reg == S_FIN) ? pos_m1_reg : idx_reg;
        mem_wdata = (state_reg == S_FIN) ? val_reg : mem_rdata;
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        pos_m1_next = pos_m1_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        lim_next    = lim_reg;
        len_next    = len_reg;
        st_next     = st_reg;
        rd_next     = rd_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pos_m1_next = pos_m1_ext[AW-1:0];
                    val_next    = value;
                    st_next     = ST_OK;
                    rd_next     = 32'd0;
                    state_next  = S_DONE;
                    case (req_type)
                        REQ_INSERT:
                        begin
                            mode_next = M_INS;
                            if (is_full)
                            begin
                                st_next = ST_FULL;
                            end
                            else if (!ins_ok)
                            begin
                                st_next = ST_INVALID;
                            end
                            else if (is_append)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                idx_next   = len_ext[AW-1:0];
                                lim_next   = pos_m1_ext[AW-1:0];
                                state_next = S_RD;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            mode_next = M_REM;
                            if (!pos_ok)
                            begin
                                st_next = ST_INVALID;
                            end
                            else if (is_last)
                            begin
                                len_next = len_reg - LW'(1);
                            end
                            else
                            begin
                                idx_next   = pos_m1_ext[AW-1:0];
                                lim_next   = len_ext[AW-1:0] - AW'(1);
                                state_next = S_RD;
                            end
                        end
                        REQ_READ:
                        begin
                            mode_next = M_RD;
                            if (!pos_ok)
                            begin
                                st_next = ST_INVALID;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        REQ_REPLACE:
                        begin
                            mode_next = M_REP;
                            if (!pos_ok)
                            begin
                                st_next = ST_INVALID;
                            end
                            else
                            begin
                                state_next = S_FIN;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            len_next = '0;
                        end
                        default:
                        begin
                            st_next = ST_OK;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                // RAM data of the previous read is valid here
                if (mode_reg == M_RD)
                begin
                    rd_next    = mem_rdata;
                    state_next = S_DONE;
                end
                else if (step_end)
                begin
                    if (mode_reg == M_INS)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        len_next   = len_reg - LW'(1);
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    idx_next   = idx_step;
                    state_next = S_RD;
                end
            end
            S_FIN:
            begin
                if (mode_reg == M_INS)
                begin
                    len_next = len_reg + LW'(1);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        pos_m1_reg <= pos_m1_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        lim_reg    <= lim_next;
        st_reg     <= st_next;
        rd_reg     <= rd_next;
    end

    // Handshake and result
    always_comb
    begin
        in_ready       = (state_reg == S_IDLE);
        res_valid      = (state_reg == S_DONE);
        res.read_value = rd_reg;
        res.status     = st_reg;
        res.list_count = len_ext[6:0];
        res.is_empty   = (len_reg == '0);
    end

endmodule

>>> rtl/core/positional_list_engine_top.sv
// One item at a time. Insert and remove shift the entries between the position and the
// end of the list, with one read/write pair on the entry RAM per moved entry.
// A new item is taken while the previous result still waits in the output register.
// Reset (rst_n, async, active low) empties the list; the entry RAM is not cleared.
module positional_list_engine_top
    import ple_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic [6:0]         position,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] read_value,
    output logic [1:0]         status,
    output logic [6:0]         list_count,
    output logic               is_empty
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);

    logic          res_valid, res_take;
    result_t       res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata, mem_rdata;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    ple_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .LW       (LW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .position  (position),
        .value     (value),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ple_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register
    always_comb
    begin
        res_take       = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_reg.read_value;
    assign status     = out_reg.status;
    assign list_count = out_reg.list_count;
    assign is_empty   = out_reg.is_empty;

endmodule

>>> tb/sv/positional_list_engine_top_tb.sv
module positional_list_engine_top_tb;
    import ple_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_LIMIT   = 2000;
    // longest insert shifts the whole list
    localparam int TAIL_CYCLES  = 3 * CAPACITY + 20;

    // request codes the block accepts but ignores
    localparam logic [2:0] REQ_SPARE_LO  = 3'd5;
    localparam logic [2:0] REQ_SPARE_MID = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI  = 3'd7;

    typedef struct {
        logic [2:0]         req;
        logic [6:0]         pos;
        logic signed [31:0] val;
        bit                 fixed;   // res below is the expected result
        result_t            res;
    } stim_row_t;

    typedef enum logic [1:0] {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_e;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         req_type;
    logic [6:0]         position;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         list_count;
    logic               is_empty;

    // mirror of the list contents, front of the queue is position 1
    logic signed [31:0] list_vals [$];
    result_t            pending_results [$];
    int                 errors     = 0;
    int                 idle_count = 0;
    int                 burst_left = 0;

    // directed items; fixed rows carry a result readable by eye
    stim_row_t directed_rows [25] = '{
        '{REQ_READ,      7'd1,   32'sd0,        1'b1, '{32'sd0, ST_INVALID, 7'd0, 1'b1}},
        '{REQ_REMOVE,    7'd0,   32'sd0,        1'b1, '{32'sd0, ST_INVALID, 7'd0, 1'b1}},
        '{REQ_REPLACE,   7'd1,   32'h12345678,  1'b1, '{32'sd0, ST_INVALID, 7'd0, 1'b1}},
        '{REQ_INSERT,    7'd0,   32'sd1,        1'b1, '{32'sd0, ST_INVALID, 7'd0, 1'b1}},
        '{REQ_INSERT,    7'd2,   32'sd1,        1'b1, '{32'sd0, ST_INVALID, 7'd0, 1'b1}},
        '{REQ_INSERT,    7'd1,   32'h7FFFFFFF,  1'b1, '{32'sd0, ST_OK,      7'd1, 1'b0}},
        '{REQ_INSERT,    7'd1,   32'h80000000,  1'b1, '{32'sd0, ST_OK,      7'd2, 1'b0}},
        '{REQ_INSERT,    7'd3,   32'hFFFFFFFF,  1'b1, '{32'sd0, ST_OK,      7'd3, 1'b0}},
        '{REQ_INSERT,    7'd2,   32'sd0,        1'b0, '0},
        '{REQ_READ,      7'd1,   32'sd0,        1'b0, '0},
        '{REQ_READ,      7'd4,   32'sd0,        1'b0, '0},
        '{REQ_READ,      7'd5,   32'sd0,        1'b1, '{32'sd0, ST_INVALID, 7'd4, 1'b0}},
        '{REQ_REPLACE,   7'd2,   32'h55555555,  1'b0, '0},
        '{REQ_READ,      7'd2,   32'sd0,        1'b0, '0},
        '{REQ_INSERT,    7'd127, 32'sd0,        1'b1, '{32'sd0, ST_INVALID, 7'd4, 1'b0}},
        '{REQ_SPARE_LO,  7'd1,   32'h0F0F0F0F,  1'b1, '{32'sd0, ST_OK,      7'd4, 1'b0}},
        '{REQ_SPARE_HI,  7'd127, 32'hFFFFFFFF,  1'b1, '{32'sd0, ST_OK,      7'd4, 1'b0}},
        '{REQ_REMOVE,    7'd4,   32'sd0,        1'b0, '0},
        '{REQ_READ,      7'd3,   32'sd0,        1'b0, '0},
        '{REQ_REMOVE,    7'd1,   32'sd0,        1'b0, '0},
        '{REQ_REMOVE,    7'd5,   32'sd0,        1'b1, '{32'sd0, ST_INVALID, 7'd2, 1'b0}},
        '{REQ_CLEAR,     7'd0,   32'sd0,        1'b1, '{32'sd0, ST_OK,      7'd0, 1'b1}},
        '{REQ_READ,      7'd1,   32'sd0,        1'b1, '{32'sd0, ST_INVALID, 7'd0, 1'b1}},
        '{REQ_INSERT,    7'd1,   32'hAAAAAAAA,  1'b1, '{32'sd0, ST_OK,      7'd1, 1'b0}},
        '{REQ_SPARE_MID, 7'd64,  32'sd0,        1'b1, '{32'sd0, ST_OK,      7'd1, 1'b0}}
    };

    // cumulative-free weights per mix: insert, remove, read, replace, bad position, clear;
    // what is left of 100 goes to the spare codes
    int unsigned mix_weights [3][6] = '{
        '{80,  2,  6,  5, 6, 0},
        '{30, 30, 15, 12, 8, 3},
        '{ 5, 75,  8,  5, 5, 2}
    };

    positional_list_engine_top #(.CAPACITY(CAPACITY)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .status     (status),
        .list_count (list_count),
        .is_empty   (is_empty)
    );

    always #10 clk = ~clk;

    // list behavior: apply one request to the mirror, return its result
    function automatic result_t list_step(input logic [2:0] rt, input logic [6:0] p,
                                          input logic signed [31:0] v);
        result_t r;
        int      len;
        int      idx;
        len = list_vals.size();
        idx = int'(p);
        r = '0;
        r.status = ST_OK;
        case (rt)
            REQ_INSERT:
                if (len >= CAPACITY)
                    r.status = ST_FULL;
                else if (idx < 1 || idx > len + 1)
                    r.status = ST_INVALID;
                else
                    list_vals.insert(idx - 1, v);
            REQ_REMOVE:
                if (idx < 1 || idx > len)
                    r.status = ST_INVALID;
                else
                    list_vals.delete(idx - 1);
            REQ_READ:
                if (idx < 1 || idx > len)
                    r.status = ST_INVALID;
                else
                    r.read_value = list_vals[idx - 1];
            REQ_REPLACE:
                if (idx < 1 || idx > len)
                    r.status = ST_INVALID;
                else
                    list_vals[idx - 1] = v;
            REQ_CLEAR:
                list_vals.delete();
            default: ;
        endcase
        r.list_count = 7'(list_vals.size());
        r.is_empty   = (list_vals.size() == 0);
        return r;
    endfunction

    // present one item, hold it until taken, then record what it should give
    task automatic issue(input logic [2:0] rt, input logic [6:0] p,
                         input logic signed [31:0] v, input bit fixed, input result_t fixed_res);
        result_t r;
        int      gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        req_type <= rt;
        position <= p;
        value    <= v;
        // ready is stable between the falling edge and the next rising edge
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        r = list_step(rt, p, v);
        if (fixed)
            r = fixed_res;
        pending_results.push_back(r);
    endtask

    // stimulus
    initial
    begin
        int          n;
        int          k;
        int          len;
        int          hi;
        int          roll;
        int          acc;
        int          pick;
        int          full_hits;
        int          churn_left;
        bit          good;
        logic [2:0]  rt;
        logic [6:0]  p;
        mix_e        mix;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_READ;
        position = 7'd0;
        value    = 32'sd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue(directed_rows[i].req, directed_rows[i].pos, directed_rows[i].val,
                  directed_rows[i].fixed, directed_rows[i].res);

        mix        = MIX_FILL;
        full_hits  = 0;
        churn_left = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            len = list_vals.size();
            // fill to full, churn for a while, then drain to empty and start over
            case (mix)
                MIX_FILL:
                    if (full_hits >= 3)
                    begin
                        mix        = MIX_CHURN;
                        churn_left = 60;
                        full_hits  = 0;
                    end
                MIX_CHURN:
                    if (churn_left == 0)
                        mix = MIX_DRAIN;
                    else
                        churn_left--;
                default:
                    if (len == 0)
                        mix = MIX_FILL;
            endcase

            roll = $urandom_range(0, 99);
            acc  = 0;
            pick = 6;
            for (k = 0; k < 6; k++)
            begin
                acc += mix_weights[mix][k];
                if (pick == 6 && roll < acc)
                    pick = k;
            end
            good = 1'b1;
            case (pick)
                0: rt = REQ_INSERT;
                1: rt = REQ_REMOVE;
                2: rt = REQ_READ;
                3: rt = REQ_REPLACE;
                4:
                begin
                    rt   = 3'($urandom_range(REQ_INSERT, REQ_REPLACE));
                    good = 1'b0;
                end
                5: rt = REQ_CLEAR;
                default: rt = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
            endcase

            hi = (rt == REQ_INSERT) ? len + 1 : len;
            if (rt == REQ_CLEAR || rt >= REQ_SPARE_LO || (rt == REQ_INSERT && len >= CAPACITY))
                p = 7'($urandom_range(0, 127));
            else if (good && hi >= 1)
                p = 7'($urandom_range(1, hi));
            else if ($urandom_range(0, 1) == 0 || hi >= 127)
                p = 7'd0;
            else
                p = 7'($urandom_range(hi + 1, 127));

            if (mix == MIX_FILL && rt == REQ_INSERT && len >= CAPACITY)
                full_hits++;
            issue(rt, p, 32'($urandom), 1'b0, '0);
        end
        in_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("positional_list_engine_top_tb: PASS");
        else
            $display("positional_list_engine_top_tb: FAIL");
        $finish;
    end

    // receiver: ready follows a 16-bit pattern, sometimes all ready, sometimes a long stall
    initial
    begin
        logic [15:0] ready_word;
        int          sel;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            sel = $urandom_range(0, 7);
            if (sel < 2)
                ready_word = 16'hFFFF;
            else if (sel == 2)
                ready_word = 16'h000F;
            else
                ready_word = 16'($urandom) | 16'($urandom);
            for (int b = 0; b < 16; b++)
            begin
                @(posedge clk);
                out_ready <= ready_word[b];
            end
        end
    end

    // result check, sampled mid-cycle ahead of the accepting edge
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result read_value=%0d status=%0d list_count=%0d",
                         $time, read_value, status, list_count);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_value !== want.read_value)
                begin
                    $display("%0t: read_value expected %0d got %0d",
                             $time, want.read_value, read_value);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, status);
                    errors++;
                end
                if (list_count !== want.list_count)
                begin
                    $display("%0t: list_count expected %0d got %0d",
                             $time, want.list_count, list_count);
                    errors++;
                end
                if (is_empty !== want.is_empty)
                begin
                    $display("%0t: is_empty expected %0d got %0d",
                             $time, want.is_empty, is_empty);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_count <= 0;
        else if (idle_count >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("positional_list_engine_top_tb: FAIL");
            $finish;
        end
        else
            idle_count <= idle_count + 1;
    end

endmodule
